// File: hdl/assert_macros.svh
// assertion macros shared by the prime test unit
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tdpt_pkg.sv
// shared types and constants of the trial division prime test unit
// used by tdpt_ctrl, tdpt_dp and the top level; no dependencies
`default_nettype none

package tdpt_pkg;

  // first trial divisor of the 6k +/- 1 wheel, its square and the first square step
  localparam int unsigned INIT_J     = 5;
  localparam int unsigned INIT_SQ    = 25;
  localparam int unsigned INIT_DELTA = 96;  // (j+6)^2 - j^2 = 12j + 36 at j = 5
  localparam int unsigned J_STEP     = 6;
  localparam int unsigned DELTA_STEP = 72;  // 12 * J_STEP
  localparam int unsigned DIV_THREE  = 3;
  localparam int unsigned PAIR_OFFS  = 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_WAIT3,
    S_CHECK,
    S_WAIT_J,
    S_WAIT_J2,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    SEL_THREE,
    SEL_J,
    SEL_J2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_lt4;
    logic n_even;
    logic div_busy;
    logic rem_zero;
    logic sq_gt_n;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/trial_division_prime_test_unit.sv
// Trial division prime test unit (top level; uses tdpt_pkg, tdpt_ctrl, tdpt_dp and
// assert_macros.svh). Each transaction on the input carries one candidate, of which the low
// NUMBER_BITS bits are tested; one transaction on the output gives is_prime. Zero and one are
// not prime, two and three are prime, other even numbers are composite. Odd
// numbers are first divided by three and then by j and j+2 for j = 5, 11, 17, ... while j*j
// does not exceed the number. All divisions run on one bit-serial remainder unit, with up to
// about sqrt(n) / 6 divisor pairs for a prime n. One item is worked on at a time; a new
// candidate is taken while the last result waits.
`default_nettype none

`include "assert_macros.svh"

module trial_division_prime_test_unit #(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] candidate,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_prime
);

  tdpt_pkg::ctrl_cmd_t  cmd;
  tdpt_pkg::dp_status_t status;
  logic                 out_free;
  logic                 out_load;
  logic                 verdict;

  assign out_free = !out_valid || !out_stall;

  tdpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .out_free (out_free),
    .out_load (out_load),
    .verdict  (verdict)
  );

  tdpt_dp #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .candidate (candidate),
    .cmd       (cmd),
    .status    (status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      is_prime <= verdict;
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "accepted a candidate but did not go busy")
  `ASSERT_IMPLIES(a_div_only_when_busy, clk, rst, status.div_busy, in_stall, "remainder unit running while input is open")
  `ASSERT_IMPLIES(a_no_result_overwrite, clk, rst, out_load, !out_valid || !out_stall, "result loaded over a waiting result")

endmodule

`default_nettype wire

// File: hdl/tdpt_dp.sv
// datapath of the prime test: candidate, wheel divisor, running square
// and a bit-serial remainder unit; depends on tdpt_pkg
`default_nettype none

module tdpt_dp #(
  parameter int unsigned NUMBER_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [31:0]           candidate,
  input  wire tdpt_pkg::ctrl_cmd_t   cmd,
  output tdpt_pkg::dp_status_t       status
);

  localparam int unsigned W  = NUMBER_BITS;
  localparam int unsigned SW = NUMBER_BITS + 2;
  localparam int unsigned CW = $clog2(NUMBER_BITS);

  logic [W-1:0]  n;
  logic [W-1:0]  j;
  logic [SW-1:0] sq;
  logic [SW-1:0] delta;
  logic [W-1:0]  divisor;
  logic [W-1:0]  rem;
  logic [CW-1:0] cnt;
  logic          div_busy;

  logic [W-1:0]  divisor_next;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  always_comb begin
    unique case (cmd.div_sel)
      tdpt_pkg::SEL_THREE: divisor_next = W'(tdpt_pkg::DIV_THREE);
      tdpt_pkg::SEL_J:     divisor_next = j;
      tdpt_pkg::SEL_J2:    divisor_next = j + W'(tdpt_pkg::PAIR_OFFS);
      default:             divisor_next = j;
    endcase
  end

  // one quotient bit per cycle, msb first; rem stays below divisor
  assign shifted = {rem, n[cnt]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n     <= W'(candidate);
      j     <= W'(tdpt_pkg::INIT_J);
      sq    <= SW'(tdpt_pkg::INIT_SQ);
      delta <= SW'(tdpt_pkg::INIT_DELTA);
    end else if (cmd.step) begin
      j     <= j + W'(tdpt_pkg::J_STEP);
      sq    <= sq + delta;
      delta <= delta + SW'(tdpt_pkg::DELTA_STEP);
    end

    if (cmd.div_start) begin
      divisor <= divisor_next;
      rem     <= '0;
      cnt     <= CW'(W - 1);
    end else if (div_busy) begin
      if (shifted >= {1'b0, divisor}) begin
        rem <= diff[W-1:0];
      end else begin
        rem <= shifted[W-1:0];
      end
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && (cnt == '0)) begin
      div_busy <= 1'b0;
    end
  end

  assign status.n_lt2    = (n[W-1:1] == '0);
  assign status.n_lt4    = (n[W-1:2] == '0);
  assign status.n_even   = ~n[0];
  assign status.div_busy = div_busy;
  assign status.rem_zero = (rem == '0);
  assign status.sq_gt_n  = (sq > SW'(n));

endmodule

`default_nettype wire

// File: hdl/tdpt_ctrl.sv
// controller of the prime test: sequences the special cases, the test by
// three and the wheel of trial divisions; depends on tdpt_pkg
`default_nettype none

module tdpt_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire tdpt_pkg::dp_status_t  status,
  output tdpt_pkg::ctrl_cmd_t        cmd,
  input  wire logic                  out_free,
  output logic                       out_load,
  output logic                       verdict
);

  tdpt_pkg::state_t state, state_next;
  logic             verdict_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdpt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    verdict <= verdict_next;
  end

  always_comb begin
    state_next   = state;
    verdict_next = verdict;
    unique case (state)
      tdpt_pkg::S_IDLE: begin
        if (in_valid) state_next = tdpt_pkg::S_CLASSIFY;
      end
      tdpt_pkg::S_CLASSIFY: begin
        priority if (status.n_lt2) begin
          verdict_next = 1'b0;
          state_next   = tdpt_pkg::S_FINISH;
        end else if (status.n_lt4) begin
          verdict_next = 1'b1;
          state_next   = tdpt_pkg::S_FINISH;
        end else if (status.n_even) begin
          verdict_next = 1'b0;
          state_next   = tdpt_pkg::S_FINISH;
        end else begin
          state_next = tdpt_pkg::S_WAIT3;
        end
      end
      tdpt_pkg::S_WAIT3: begin
        if (!status.div_busy) begin
          if (status.rem_zero) begin
            verdict_next = 1'b0;
            state_next   = tdpt_pkg::S_FINISH;
          end else begin
            state_next = tdpt_pkg::S_CHECK;
          end
        end
      end
      tdpt_pkg::S_CHECK: begin
        // square of the divisor past the candidate: no factor left to find
        if (status.sq_gt_n) begin
          verdict_next = 1'b1;
          state_next   = tdpt_pkg::S_FINISH;
        end else begin
          state_next = tdpt_pkg::S_WAIT_J;
        end
      end
      tdpt_pkg::S_WAIT_J: begin
        if (!status.div_busy) begin
          if (status.rem_zero) begin
            verdict_next = 1'b0;
            state_next   = tdpt_pkg::S_FINISH;
          end else begin
            state_next = tdpt_pkg::S_WAIT_J2;
          end
        end
      end
      tdpt_pkg::S_WAIT_J2: begin
        if (!status.div_busy) begin
          if (status.rem_zero) begin
            verdict_next = 1'b0;
            state_next   = tdpt_pkg::S_FINISH;
          end else begin
            state_next = tdpt_pkg::S_CHECK;
          end
        end
      end
      tdpt_pkg::S_FINISH: begin
        if (out_free) state_next = tdpt_pkg::S_IDLE;
      end
      default: begin
        state_next = tdpt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = tdpt_pkg::SEL_THREE;
    cmd.step      = 1'b0;
    out_load      = 1'b0;
    in_stall      = (state != tdpt_pkg::S_IDLE);
    unique case (state)
      tdpt_pkg::S_IDLE: begin
        cmd.load = in_valid;
      end
      tdpt_pkg::S_CLASSIFY: begin
        cmd.div_start = !(status.n_lt2 || status.n_lt4 || status.n_even);
        cmd.div_sel   = tdpt_pkg::SEL_THREE;
      end
      tdpt_pkg::S_WAIT3: begin
      end
      tdpt_pkg::S_CHECK: begin
        cmd.div_start = !status.sq_gt_n;
        cmd.div_sel   = tdpt_pkg::SEL_J;
      end
      tdpt_pkg::S_WAIT_J: begin
        cmd.div_start = !status.div_busy && !status.rem_zero;
        cmd.div_sel   = tdpt_pkg::SEL_J2;
      end
      tdpt_pkg::S_WAIT_J2: begin
        cmd.step = !status.div_busy && !status.rem_zero;
      end
      tdpt_pkg::S_FINISH: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: tb/sv/tdpt_result_checker.sv
// result checker for the trial division prime test unit: watches both channels,
// predicts is_prime for every accepted candidate and compares in order; no dependencies
`timescale 1ns / 1ps

module tdpt_result_checker #(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] candidate,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        is_prime,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [31:0] number;
    logic        verdict;
  } verdict_t;

  verdict_t expected_verdicts[$];

  // 6k +/- 1 wheel; bound j*j <= n written as j <= n / j so it cannot overflow
  function automatic logic wheel_is_prime(logic [31:0] raw);
    longint unsigned num;
    longint unsigned j;
    num = longint'(raw) & ({64{1'b1}} >> (64 - NUMBER_BITS));
    if (num < 2) return 1'b0;
    if (num < 4) return 1'b1;
    if ((num % 2) == 0 || (num % 3) == 0) return 1'b0;
    for (j = 5; j <= num / j; j += 6) begin
      if ((num % j) == 0 || (num % (j + 2)) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t head;
    verdict_t fresh;
    if (rst) begin
      expected_verdicts.delete();
      pending = 0;
    end else begin
      // pop before push: a result can never belong to a transaction taken at the same edge
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result is_prime=%0b", $realtime, is_prime);
        end else begin
          head = expected_verdicts.pop_front();
          if (is_prime !== head.verdict) begin
            errors++;
            if (errors <= 10)
              $display("%0t: candidate %0d: expected is_prime=%0b, got %0b",
                       $realtime, head.number, head.verdict, is_prime);
          end
        end
      end
      if (in_valid && !in_stall) begin
        fresh.number  = candidate;
        fresh.verdict = wheel_is_prime(candidate);
        expected_verdicts.push_back(fresh);
      end
      pending = expected_verdicts.size();
    end
  end

endmodule

// File: tb/sv/tb_trial_division_prime_test_unit.sv
// testbench top for trial_division_prime_test_unit: directed and random candidates in bursts,
// random output stalls; depends on the block and on tdpt_result_checker
`timescale 1ns / 1ps

module tb_trial_division_prime_test_unit;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] candidate = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_prime;
  int          errors;
  int          pending;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  trial_division_prime_test_unit #(.NUMBER_BITS(32)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .candidate (candidate),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_prime  (is_prime)
  );

  tdpt_result_checker #(.NUMBER_BITS(32)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .candidate (candidate),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_prime  (is_prime),
    .errors    (errors),
    .pending   (pending)
  );

  // output stall: phases of no stall, random stall and a fixed duty pattern
  int unsigned stall_mode  = 0;
  int unsigned stall_phase = 0;
  int unsigned stall_tick  = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_phase == 0) begin
        stall_mode  <= $urandom_range(0, 2);
        stall_phase <= $urandom_range(16, 300);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ((stall_tick % 11) < 6);
      endcase
    end
  end

  initial begin
    logic [31:0] stimulus_numbers[$];
    int unsigned wheel_factors[8];
    int unsigned kind;
    int unsigned factor;
    logic [31:0] value;
    int unsigned next_idx;
    int unsigned burst_len;
    int unsigned gap_len;
    bit          accepted;

    wheel_factors = '{2, 3, 5, 7, 11, 13, 17, 19};

    // zero and one, two and three, small evens, squares on the loop bound,
    // all-ones and all-zeros patterns, deep loops with a prime and a prime square
    stimulus_numbers = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 25, 29, 31, 35, 49, 97, 121,
                         32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h5555_5555,
                         65521, 65535, 16777213, 32'd16752649};

    repeat (115) begin
      kind = $urandom_range(0, 19);
      if (kind < 10) begin
        value = $urandom_range(0, 4095);
      end else if (kind < 13) begin
        value = $urandom_range(0, 65535);
      end else if (kind < 19) begin
        // full-width value with a small factor so the loop ends early
        factor = wheel_factors[$urandom_range(0, 7)];
        value  = $urandom;
        value  = value - (value % factor);
      end else begin
        value = $urandom_range(0, 1048575) | 32'd1;
      end
      stimulus_numbers.push_back(value);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    next_idx = 0;
    while (next_idx < stimulus_numbers.size()) begin
      burst_len = $urandom_range(1, 12);
      gap_len   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      while (burst_len > 0 && next_idx < stimulus_numbers.size()) begin
        in_valid  <= 1'b1;
        candidate <= stimulus_numbers[next_idx];
        // inputs only change at the rising edge, so the stall seen at the falling edge holds
        do begin
          @(negedge clk);
          accepted = !in_stall;
          @(posedge clk);
        end while (!accepted);
        next_idx++;
        burst_len--;
      end
      if (gap_len > 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // let the checker record the last transaction before looking at its count
    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("trial_division_prime_test_unit test passed");
    else
      $display("trial_division_prime_test_unit test failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("trial_division_prime_test_unit test failed");
    $finish;
  end

endmodule
